// ===== rtl/sct_pkg.sv =====
`timescale 1ns / 1ps

package sct_pkg;

    // Token kinds on the output channel
    typedef enum logic [3:0] {
        K_BYTE = 4'd0,
        K_WEND = 4'd1,
        K_GT   = 4'd2,
        K_GTGT = 4'd3,
        K_LT   = 4'd4,
        K_PIPE = 4'd5,
        K_AMP  = 4'd6,
        K_SEMI = 4'd7,
        K_ERR  = 4'd8,
        K_DONE = 4'd9
    } kind_t;

    // One result beat
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } res_t;

    // Results of one input beat, handed from the lexer to the output queue
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    // Character codes
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_PIPE = 8'h7C;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;

    // Output queue depth and its pointer width
    localparam int QDEPTH = 4;
    localparam int QPW    = 2;

endpackage

// ===== rtl/sct_cmd_if.sv =====
`timescale 1ns / 1ps

interface sct_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_end;

    modport source (output valid, output ch, output line_end, input ready);
    modport sink   (input valid, input ch, input line_end, output ready);
endinterface

// ===== rtl/sct_tok_if.sv =====
`timescale 1ns / 1ps

interface sct_tok_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] data;
    logic       last_of_run;

    modport source (output valid, output kind, output data, output last_of_run, input ready);
    modport sink   (input valid, input kind, input data, input last_of_run, output ready);
endinterface

// ===== rtl/shell_command_tokenizer_top.sv =====
`timescale 1ns / 1ps

// Streaming command-line tokenizer. Takes one byte beat per cycle on cmd
// (line_end beats close a line) while the output drains, and gives word
// bytes, word ends, operator tokens, error and line-done beats on tok, one
// beat per cycle while tok is ready. A byte beat is held in an input
// register, decoded combinationally against the lexer mode and its zero to
// two results are written to a four-entry output queue, so the first result
// is offered on tok from the queue once it has passed the input register
// and the queue write. Input takes one beat per cycle as long as the output
// drains; the input register holds its byte while the queue has fewer than
// two free entries. The sustained rate is set by the single-beat tok port,
// so a byte that causes two results uses the port once for each. Downstream
// should drop all tokens of a line that ends in an error beat.
module shell_command_tokenizer_top (
    input  logic      clk,
    input  logic      rst_n,
    sct_cmd_if.sink   cmd,
    sct_tok_if.source tok
);

    sct_pkg::push_t push;
    logic           space_ok;

    sct_lexer u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .space_ok (space_ok),
        .push     (push)
    );

    sct_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .tok      (tok)
    );

    // results are only written when the queue has room for a pair
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> space_ok)
        else $error("result write without queue space");

    // exactly the final result of a beat carries the last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |-> (push.r1.last && !push.r0.last))
        else $error("bad last flag on result pair");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd1) |-> push.r0.last)
        else $error("single result without last flag");

    // line done is always the final result of its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |-> (push.r0.kind != sct_pkg::K_DONE))
        else $error("line done followed by another result");

endmodule

// ===== rtl/sct_lexer.sv =====
`timescale 1ns / 1ps

module sct_lexer (
    input  logic             clk,
    input  logic             rst_n,
    sct_cmd_if.sink          cmd,
    input  logic             space_ok,
    output sct_pkg::push_t   push
);

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_WORD = 3'd1,
        M_WESC = 3'd2,
        M_SQ   = 3'd3,
        M_DQ   = 3'd4,
        M_DESC = 3'd5,
        M_GT   = 3'd6
    } mode_t;

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       end_reg;
    mode_t      mode_reg;
    mode_t      mode_next;

    logic       advance;

    // start-of-token decode of the held byte
    logic              blank;
    logic              oper;
    logic              sb_v;
    sct_pkg::kind_t    sb_kind;
    mode_t             sb_mode;

    // up to two results: a goes first
    logic              a_v;
    sct_pkg::kind_t    a_kind;
    logic [7:0]        a_data;
    logic              b_v;
    sct_pkg::kind_t    b_kind;
    logic [7:0]        b_data;

    assign advance   = in_valid_reg && space_ok;
    assign cmd.ready = !in_valid_reg || space_ok;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            ch_reg  <= cmd.ch;
            end_reg <= cmd.line_end;
        end
    end

    // lexer mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
        end
    end

    // byte classes
    assign blank = (ch_reg == sct_pkg::CH_SP) || (ch_reg == sct_pkg::CH_TAB) ||
                   (ch_reg == sct_pkg::CH_NL) || (ch_reg == sct_pkg::CH_CR);
    assign oper  = (ch_reg == sct_pkg::CH_PIPE) || (ch_reg == sct_pkg::CH_AMP) ||
                   (ch_reg == sct_pkg::CH_SEMI) || (ch_reg == sct_pkg::CH_LT) ||
                   (ch_reg == sct_pkg::CH_GT);

    // byte seen between tokens
    always_comb
    begin
        sb_v    = 1'b0;
        sb_kind = sct_pkg::K_BYTE;
        sb_mode = M_IDLE;
        if (blank)
        begin
            sb_v = 1'b0;
        end
        else
        begin
            unique case (ch_reg)
                sct_pkg::CH_GT:   sb_mode = M_GT;
                sct_pkg::CH_LT:   begin sb_v = 1'b1; sb_kind = sct_pkg::K_LT;   end
                sct_pkg::CH_PIPE: begin sb_v = 1'b1; sb_kind = sct_pkg::K_PIPE; end
                sct_pkg::CH_AMP:  begin sb_v = 1'b1; sb_kind = sct_pkg::K_AMP;  end
                sct_pkg::CH_SEMI: begin sb_v = 1'b1; sb_kind = sct_pkg::K_SEMI; end
                sct_pkg::CH_BSL:  sb_mode = M_WESC;
                sct_pkg::CH_SQ:   sb_mode = M_SQ;
                sct_pkg::CH_DQ:   sb_mode = M_DQ;
                default:
                begin
                    sb_v    = 1'b1;
                    sb_kind = sct_pkg::K_BYTE;
                    sb_mode = M_WORD;
                end
            endcase
        end
    end

    // per-mode results and next mode
    always_comb
    begin
        a_v       = 1'b0;
        a_kind    = sct_pkg::K_BYTE;
        a_data    = 8'd0;
        b_v       = 1'b0;
        b_kind    = sct_pkg::K_BYTE;
        b_data    = 8'd0;
        mode_next = mode_reg;
        if (end_reg)
        begin
            mode_next = M_IDLE;
            b_v       = 1'b1;
            b_kind    = sct_pkg::K_DONE;
            unique case (mode_reg)
                M_WORD:                      begin a_v = 1'b1; a_kind = sct_pkg::K_WEND; end
                M_GT:                        begin a_v = 1'b1; a_kind = sct_pkg::K_GT;   end
                M_WESC, M_SQ, M_DQ, M_DESC:  begin a_v = 1'b1; a_kind = sct_pkg::K_ERR;  end
                default:                     a_v = 1'b0;
            endcase
        end
        else
        begin
            unique case (mode_reg)
                M_WORD:
                begin
                    a_v       = blank || oper;
                    a_kind    = sct_pkg::K_WEND;
                    b_v       = sb_v;
                    b_kind    = sb_kind;
                    b_data    = (sb_kind == sct_pkg::K_BYTE) ? ch_reg : 8'd0;
                    mode_next = sb_mode;
                end
                M_WESC:
                begin
                    b_v       = 1'b1;
                    b_data    = ch_reg;
                    mode_next = M_WORD;
                end
                M_SQ:
                begin
                    if (ch_reg == sct_pkg::CH_SQ)
                    begin
                        mode_next = M_WORD;
                    end
                    else
                    begin
                        b_v    = 1'b1;
                        b_data = ch_reg;
                    end
                end
                M_DQ:
                begin
                    if (ch_reg == sct_pkg::CH_DQ)
                    begin
                        mode_next = M_WORD;
                    end
                    else if (ch_reg == sct_pkg::CH_BSL)
                    begin
                        mode_next = M_DESC;
                    end
                    else
                    begin
                        b_v    = 1'b1;
                        b_data = ch_reg;
                    end
                end
                M_DESC:
                begin
                    // only \" and \\ collapse; other pairs keep the backslash
                    a_v       = (ch_reg != sct_pkg::CH_DQ) && (ch_reg != sct_pkg::CH_BSL);
                    a_data    = sct_pkg::CH_BSL;
                    b_v       = 1'b1;
                    b_data    = ch_reg;
                    mode_next = M_DQ;
                end
                M_GT:
                begin
                    if (ch_reg == sct_pkg::CH_GT)
                    begin
                        b_v       = 1'b1;
                        b_kind    = sct_pkg::K_GTGT;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        a_v       = 1'b1;
                        a_kind    = sct_pkg::K_GT;
                        b_v       = sb_v;
                        b_kind    = sb_kind;
                        b_data    = (sb_kind == sct_pkg::K_BYTE) ? ch_reg : 8'd0;
                        mode_next = sb_mode;
                    end
                end
                default:
                begin
                    b_v       = sb_v;
                    b_kind    = sb_kind;
                    b_data    = (sb_kind == sct_pkg::K_BYTE) ? ch_reg : 8'd0;
                    mode_next = sb_mode;
                end
            endcase
        end
    end

    // pack results, first one in r0, final one flagged last
    always_comb
    begin
        push    = '0;
        if (advance)
        begin
            if (a_v && b_v)
            begin
                push.n  = 2'd2;
                push.r0 = '{kind: a_kind, data: a_data, last: 1'b0};
                push.r1 = '{kind: b_kind, data: b_data, last: 1'b1};
            end
            else if (a_v)
            begin
                push.n  = 2'd1;
                push.r0 = '{kind: a_kind, data: a_data, last: 1'b1};
            end
            else if (b_v)
            begin
                push.n  = 2'd1;
                push.r0 = '{kind: b_kind, data: b_data, last: 1'b1};
            end
        end
    end

endmodule

// ===== rtl/sct_out_queue.sv =====
`timescale 1ns / 1ps

module sct_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  sct_pkg::push_t   push,
    output logic             space_ok,
    sct_tok_if.source        tok
);

    sct_pkg::res_t              q_mem [sct_pkg::QDEPTH];
    logic [sct_pkg::QPW-1:0]    wr_ptr_reg;
    logic [sct_pkg::QPW-1:0]    rd_ptr_reg;
    logic [sct_pkg::QPW:0]      count_reg;
    logic [sct_pkg::QPW:0]      count_next;
    logic                       pop;
    logic [sct_pkg::QPW-1:0]    wr_ptr_1;

    // room for a full pair of results
    assign space_ok = (count_reg <= (sct_pkg::QPW + 1)'(sct_pkg::QDEPTH - 2));
    assign pop      = tok.valid && tok.ready;
    assign wr_ptr_1 = wr_ptr_reg + 1'b1;

    assign count_next = count_reg + (sct_pkg::QPW + 1)'(push.n) - (sct_pkg::QPW + 1)'(pop);

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push.n[sct_pkg::QPW-1:0];
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            q_mem[wr_ptr_1] <= push.r1;
        end
    end

    // head beat
    assign tok.valid       = (count_reg != '0);
    assign tok.kind        = q_mem[rd_ptr_reg].kind;
    assign tok.data        = q_mem[rd_ptr_reg].data;
    assign tok.last_of_run = q_mem[rd_ptr_reg].last;

endmodule

// ===== tb/sv/tb_shell_command_tokenizer_top.sv =====
`timescale 1ns / 1ps

module tb_shell_command_tokenizer_top;
    import sct_pkg::*;

    localparam int RAND_ITEMS   = 1600;
    localparam int SETTLE_TICKS = 6;

    // Lexer modes of the predictor
    typedef enum logic [2:0] {
        LX_IDLE = 3'd0,
        LX_WORD = 3'd1,
        LX_WESC = 3'd2,
        LX_SQ   = 3'd3,
        LX_DQ   = 3'd4,
        LX_DESC = 3'd5,
        LX_GT   = 3'd6
    } lex_mode_e;

    // Predicts the token beats of each accepted command beat and checks the output
    class token_scoreboard;
        lex_mode_e mode;
        res_t      expected_tokens[$];
        res_t      run[$];
        int        errors;

        function new();
            mode   = LX_IDLE;
            errors = 0;
        endfunction

        static function bit is_blank(logic [7:0] c);
            return c == CH_SP || c == CH_TAB || c == CH_NL || c == CH_CR;
        endfunction

        static function bit is_oper(logic [7:0] c);
            return c == CH_PIPE || c == CH_AMP || c == CH_SEMI || c == CH_LT || c == CH_GT;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void emit(kind_t k, logic [7:0] d);
            res_t r;
            r.kind = k;
            r.data = d;
            r.last = 1'b0;
            run.push_back(r);
        endfunction

        // Byte seen with no token open
        function void lex_fresh(logic [7:0] c);
            mode = LX_IDLE;
            if (!is_blank(c))
                case (c)
                    CH_GT:   mode = LX_GT;
                    CH_LT:   emit(K_LT, 8'h00);
                    CH_PIPE: emit(K_PIPE, 8'h00);
                    CH_AMP:  emit(K_AMP, 8'h00);
                    CH_SEMI: emit(K_SEMI, 8'h00);
                    CH_BSL:  mode = LX_WESC;
                    CH_SQ:   mode = LX_SQ;
                    CH_DQ:   mode = LX_DQ;
                    default:
                    begin
                        emit(K_BYTE, c);
                        mode = LX_WORD;
                    end
                endcase
        endfunction

        function void note_cmd_beat(logic [7:0] c, logic line_end);
            run.delete();
            if (line_end)
            begin
                case (mode)
                    LX_WORD: emit(K_WEND, 8'h00);
                    LX_GT:   emit(K_GT, 8'h00);
                    LX_WESC, LX_SQ, LX_DQ, LX_DESC: emit(K_ERR, 8'h00);
                    default: ;
                endcase
                emit(K_DONE, 8'h00);
                mode = LX_IDLE;
            end
            else
            begin
                case (mode)
                    LX_WORD:
                    begin
                        if (is_blank(c) || is_oper(c))
                            emit(K_WEND, 8'h00);
                        lex_fresh(c);
                    end
                    LX_WESC:
                    begin
                        emit(K_BYTE, c);
                        mode = LX_WORD;
                    end
                    LX_SQ:
                    begin
                        if (c == CH_SQ)
                            mode = LX_WORD;
                        else
                            emit(K_BYTE, c);
                    end
                    LX_DQ:
                    begin
                        if (c == CH_DQ)
                            mode = LX_WORD;
                        else if (c == CH_BSL)
                            mode = LX_DESC;
                        else
                            emit(K_BYTE, c);
                    end
                    LX_DESC:
                    begin
                        // only \" and \\ collapse inside double quotes
                        if (c != CH_DQ && c != CH_BSL)
                            emit(K_BYTE, CH_BSL);
                        emit(K_BYTE, c);
                        mode = LX_DQ;
                    end
                    LX_GT:
                    begin
                        if (c == CH_GT)
                        begin
                            emit(K_GTGT, 8'h00);
                            mode = LX_IDLE;
                        end
                        else
                        begin
                            emit(K_GT, 8'h00);
                            lex_fresh(c);
                        end
                    end
                    default: lex_fresh(c);
                endcase
            end
            if (run.size() > 0)
                run[run.size() - 1].last = 1'b1;
            foreach (run[i])
                expected_tokens.push_back(run[i]);
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_token_beat(logic [3:0] kind, logic [7:0] data, logic last);
            res_t want;
            if (expected_tokens.size() == 0)
                report($sformatf("unexpected token kind=%0d data=%02h last=%0b",
                                 kind, data, last));
            else
            begin
                want = expected_tokens.pop_front();
                if (kind !== want.kind || data !== want.data || last !== want.last)
                    report($sformatf({"token kind=%0d data=%02h last=%0b, ",
                                      "wanted kind=%0d data=%02h last=%0b"},
                                     kind, data, last, want.kind, want.data, want.last));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   sent;

    token_scoreboard sb = new();

    sct_cmd_if cmd_bus ();
    sct_tok_if tok_bus ();

    shell_command_tokenizer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .tok   (tok_bus)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Reset, once
    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver backpressure
    initial
    begin
        tok_bus.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            tok_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && tok_bus.valid && tok_bus.ready)
            sb.check_token_beat(tok_bus.kind, tok_bus.data, tok_bus.last_of_run);
    end

    // One command beat; called and returns at a falling edge, valid left high
    task automatic send_item(input logic [7:0] c, input logic line_end);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.ch       <= c;
        cmd_bus.line_end <= line_end;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        sb.note_cmd_beat(c, line_end);
        sent++;
        @(negedge clk);
    endtask

    // Stop sending and let every expected token come out
    task automatic wait_for_drain();
        cmd_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] blank_byte();
        logic [7:0] blanks[4] = '{CH_SP, CH_TAB, CH_NL, CH_CR};
        return blanks[2'($urandom_range(3))];
    endfunction

    // Any byte that stays inside a bare word
    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (token_scoreboard::is_blank(c) || token_scoreboard::is_oper(c) ||
               c == CH_SQ || c == CH_DQ || c == CH_BSL);
        return c;
    endfunction

    task automatic send_oper();
        logic [7:0] ops[5] = '{CH_GT, CH_LT, CH_PIPE, CH_AMP, CH_SEMI};
        int pick;
        pick = $urandom_range(5);
        if (pick == 5)
        begin
            send_item(CH_GT, 1'b0);
            send_item(CH_GT, 1'b0);
        end
        else
            send_item(ops[pick], 1'b0);
    endtask

    // Bare run, quoted string or escape pair
    task automatic send_word_piece();
        logic [7:0] c;
        int pick;
        pick = $urandom_range(3);
        case (pick)
            0: repeat ($urandom_range(1, 4)) send_item(word_byte(), 1'b0);
            1:
            begin
                send_item(CH_SQ, 1'b0);
                repeat ($urandom_range(0, 3))
                begin
                    do
                        c = 8'($urandom_range(255));
                    while (c == CH_SQ);
                    send_item(c, 1'b0);
                end
                send_item(CH_SQ, 1'b0);
            end
            2:
            begin
                send_item(CH_DQ, 1'b0);
                repeat ($urandom_range(0, 3))
                begin
                    if ($urandom_range(2) == 0)
                    begin
                        send_item(CH_BSL, 1'b0);
                        case ($urandom_range(2))
                            0: send_item(CH_DQ, 1'b0);
                            1: send_item(CH_BSL, 1'b0);
                            default: send_item(8'($urandom_range(255)), 1'b0);
                        endcase
                    end
                    else
                    begin
                        do
                            c = 8'($urandom_range(255));
                        while (c == CH_DQ || c == CH_BSL);
                        send_item(c, 1'b0);
                    end
                end
                send_item(CH_DQ, 1'b0);
            end
            default:
            begin
                send_item(CH_BSL, 1'b0);
                send_item(8'($urandom_range(255)), 1'b0);
            end
        endcase
    endtask

    // Balanced line of words, operators and blanks
    task automatic send_wellformed_line();
        int pick;
        repeat ($urandom_range(1, 6))
        begin
            pick = $urandom_range(9);
            if (pick < 6)
                repeat ($urandom_range(1, 3)) send_word_piece();
            else if (pick < 8)
                send_oper();
            else
                send_item(blank_byte(), 1'b0);
            if ($urandom_range(1))
                send_item(blank_byte(), 1'b0);
        end
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    // Loose bytes heavy in quotes and escapes, often left unclosed
    task automatic send_noise_line();
        int pick;
        repeat ($urandom_range(1, 12))
        begin
            pick = $urandom_range(9);
            case (pick)
                5: send_item(CH_SQ, 1'b0);
                6: send_item(CH_DQ, 1'b0);
                7: send_item(CH_BSL, 1'b0);
                8: send_item(CH_GT, 1'b0);
                9: send_item(blank_byte(), 1'b0);
                default: send_item(8'($urandom_range(255)), 1'b0);
            endcase
        end
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    // Directed lines, then three random phases
    initial
    begin
        int target;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.ch       <= 8'h00;
        cmd_bus.line_end <= 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 65;
        sent          = 0;
        @(posedge rst_n);
        @(negedge clk);

        // word ended by '>' then append munch, zero byte word, operators
        send_item("x", 1'b0);
        send_item(CH_GT, 1'b0);
        send_item(CH_GT, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(CH_LT, 1'b0);
        send_item(CH_AMP, 1'b0);
        send_item(CH_SEMI, 1'b0);
        send_item(CH_PIPE, 1'b0);
        // pending '>' followed by a word byte
        send_item(CH_GT, 1'b0);
        send_item("y", 1'b0);
        // empty single quotes inside a word, double quote escapes
        send_item(CH_SQ, 1'b0);
        send_item(CH_SQ, 1'b0);
        send_item(CH_DQ, 1'b0);
        send_item(CH_BSL, 1'b0);
        send_item("n", 1'b0);
        send_item(CH_BSL, 1'b0);
        send_item(CH_DQ, 1'b0);
        send_item(CH_BSL, 1'b0);
        send_item(CH_BSL, 1'b0);
        send_item(CH_DQ, 1'b0);
        send_item(CH_TAB, 1'b0);
        // escaped blank, line end inside a word
        send_item(8'hFF, 1'b0);
        send_item(CH_BSL, 1'b0);
        send_item(CH_SP, 1'b0);
        send_item(8'hAA, 1'b1);
        // line end after pending '>', in open quote, after backslash
        send_item(CH_CR, 1'b0);
        send_item(CH_GT, 1'b0);
        send_item(8'h55, 1'b1);
        send_item(CH_DQ, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(CH_BSL, 1'b0);
        send_item(8'hFF, 1'b1);
        // empty quotes alone form a word; bare line end
        send_item(CH_SQ, 1'b0);
        send_item(CH_SQ, 1'b0);
        send_item(CH_NL, 1'b1);
        send_item(CH_NL, 1'b1);

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph != 0)
                wait_for_drain();
            case (ph)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = sent + RAND_ITEMS / 3;
            while (sent < target)
            begin
                if ($urandom_range(4) == 0)
                    send_noise_line();
                else
                    send_wellformed_line();
            end
        end

        wait_for_drain();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
